// ===== rtl/kltd_pkg.sv =====
// shared types, constants and tables of the keyed text line decoder
package kltd_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int HDR_TEXT_LEN = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_SEP_LOW  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEP_HIGH = 8'd1;

  localparam logic [63:0] SEP_LOW_RESET  = 64'h0400_1001_0000_2600;
  localparam logic [63:0] SEP_HIGH_RESET = 64'h0;

  localparam logic [7:0] BYTE_HASH  = 8'h23;
  localparam logic [7:0] BYTE_LT    = 8'h3C;
  localparam logic [7:0] BYTE_GT    = 8'h3E;
  localparam logic [7:0] DEC_LO     = 8'd33;
  localparam logic [7:0] DEC_HI     = 8'd127;
  localparam logic [7:0] WRAP_ADD   = 8'd95;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  typedef enum logic [1:0] {
    MODE_UNDEC = 2'd0,
    MODE_PLAIN = 2'd1,
    MODE_ENC   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_FLUSH = 2'd1,
    ST_CUR   = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic run;    // process the accepted input item
    logic flush;  // release one held header byte
    logic cur;    // process the saved item after a flush
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;   // output register can take a result
    logic need_flush;  // input item breaks a partial header
    logic flush_done;  // last held byte is being released
  } dp_status_t;

  function automatic logic [7:0] hdr_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h72;  // r
      4'd1:    c = 8'h65;  // e
      4'd2:    c = 8'h64;  // d
      4'd3:    c = 8'h73;  // s
      4'd4:    c = 8'h68;  // h
      4'd5:    c = 8'h69;  // i
      4'd6:    c = 8'h72;  // r
      4'd7:    c = 8'h74;  // t
      4'd8:    c = 8'h32;  // 2
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] key_offset(input logic [3:0] k);
    logic [7:0] o;
    case (k)
      4'd0:    o = 8'd31;
      4'd1:    o = 8'd7;
      4'd2:    o = 8'd9;
      4'd3:    o = 8'd1;
      4'd4:    o = 8'd11;
      4'd5:    o = 8'd2;
      4'd6:    o = 8'd5;
      4'd7:    o = 8'd5;
      4'd8:    o = 8'd3;
      4'd9:    o = 8'd17;
      4'd10:   o = 8'd40;
      4'd11:   o = 8'd12;
      4'd12:   o = 8'd35;
      4'd13:   o = 8'd22;
      4'd14:   o = 8'd27;
      4'd15:   o = 8'd2;
      default: o = 8'd0;
    endcase
    return o;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return (b >= UPPER_A && b <= UPPER_Z) ? b + CASE_DELTA : b;
  endfunction

endpackage

// ===== rtl/kltd_ctrl.sv =====
// control state machine: input acceptance and header flush sequencing
module kltd_ctrl import kltd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_RUN: begin
        in_ready = status.slot_free;
        if (in_valid && status.slot_free) begin
          cmd.run = 1'b1;
          if (status.need_flush) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (status.slot_free) begin
          cmd.flush = 1'b1;
          if (status.flush_done) begin
            state_next = ST_CUR;
          end
        end
      end
      ST_CUR: begin
        if (status.slot_free) begin
          cmd.cur    = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // no new item while held bytes or the saved item are being released
  a_no_accept_in_flush: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> !in_ready)
    else $error("input accepted during flush");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command");

endmodule

// ===== rtl/kltd_dp.sv =====
// datapath: header match, decryption, line classification and output register
module kltd_dp import kltd_pkg::*; #(
  parameter int HEADER_LENGTH = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output logic                   o_valid,
  input  logic                   o_ready,
  output logic [7:0]             o_byte,
  output logic [3:0]             o_user,
  output logic                   o_last
);

  localparam int HELD_DEPTH = (HEADER_LENGTH > 1) ? HEADER_LENGTH - 1 : 1;
  localparam int IDX_W = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam logic [4:0] HL5  = 5'(HEADER_LENGTH);
  localparam logic [4:0] TXT5 = 5'(HDR_TEXT_LEN);

  logic [63:0]      sep_low, sep_high;
  mode_t            mode;
  logic [3:0]       hm;
  logic [7:0]       held [HELD_DEPTH];
  logic [3:0]       key_pos;
  logic             in_comment;
  logic [1:0]       bracket_run;
  logic             prev_sep;
  logic [7:0]       saved_byte;
  logic             saved_last;
  logic [IDX_W-1:0] flush_idx;

  // header compare
  logic       hdr_match, hdr_done, hdr_hold, hdr_miss;
  logic [3:0] pm1;
  always_comb begin
    hdr_match = ({1'b0, hm} < TXT5) && ({1'b0, hm} < HL5) &&
                (fold_case(in_byte) == hdr_char(hm));
    hdr_done  = hdr_match && (({1'b0, hm} + 5'd1) >= HL5);
    hdr_hold  = hdr_match && !hdr_done && !in_last;
    hdr_miss  = !hdr_done && !hdr_hold;
    pm1       = hm - 4'd1;
  end

  // decryption of the input byte
  logic       in_dec;
  logic [3:0] kp_next;
  logic [7:0] off, diff, dec;
  always_comb begin
    in_dec  = (mode == MODE_ENC) && (in_byte >= DEC_LO) && (in_byte <= DEC_HI);
    kp_next = key_pos + 4'd1;
    off     = key_offset(kp_next);
    diff    = in_byte - off;
    dec     = (in_byte < off + DEC_LO) ? diff + WRAP_ADD : diff;
  end

  // select the byte for line handling
  logic       hb_en, hb_last, hb_drop;
  logic [7:0] hb_byte;
  always_comb begin
    hb_en   = 1'b0;
    hb_last = 1'b0;
    hb_drop = 1'b0;
    hb_byte = in_byte;
    if (cmd.flush) begin
      hb_en   = 1'b1;
      hb_byte = held[flush_idx];
    end else if (cmd.cur) begin
      hb_en   = 1'b1;
      hb_byte = saved_byte;
      hb_last = saved_last;
    end else if (cmd.run) begin
      if (mode == MODE_UNDEC) begin
        if (hdr_done) begin
          // header complete: only a bare line end can come out
          hb_en   = in_last;
          hb_drop = 1'b1;
          hb_last = in_last;
        end else if (hdr_miss && hm == 4'd0) begin
          hb_en   = 1'b1;
          hb_last = in_last;
        end
      end else begin
        hb_en   = 1'b1;
        hb_last = in_last;
        hb_byte = in_dec ? dec : in_byte;
      end
    end
  end

  // comment, bracket and separator handling
  logic       sep, is_hash, is_br, keep, emit, mc;
  logic [1:0] br_inc;
  always_comb begin
    if (!hb_byte[7] && !hb_byte[6]) begin
      sep = sep_low[hb_byte[5:0]];
    end else if (!hb_byte[7]) begin
      sep = sep_high[hb_byte[5:0]];
    end else begin
      sep = 1'b0;
    end
    is_hash = (hb_byte == BYTE_HASH);
    is_br   = (hb_byte == BYTE_LT) || (hb_byte == BYTE_GT);
    keep    = hb_en && !hb_drop && !in_comment && !is_hash;
    emit    = keep || (hb_en && hb_last);
    br_inc  = (bracket_run == 2'd3) ? 2'd3 : bracket_run + 2'd1;
    mc      = is_br && (br_inc == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_low     <= SEP_LOW_RESET;
      sep_high    <= SEP_HIGH_RESET;
      mode        <= MODE_UNDEC;
      hm          <= 4'd0;
      key_pos     <= 4'd0;
      in_comment  <= 1'b0;
      bracket_run <= 2'd0;
      prev_sep    <= 1'b1;
      flush_idx   <= '0;
      o_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SEP_LOW:  sep_low  <= cfg_data;
          REG_SEP_HIGH: sep_high <= cfg_data;
          default: ;
        endcase
      end

      if (hb_en) begin
        if (hb_last) begin
          in_comment  <= 1'b0;
          bracket_run <= 2'd0;
          prev_sep    <= 1'b1;
        end else if (!hb_drop && !in_comment) begin
          if (is_hash) begin
            in_comment  <= 1'b1;
            bracket_run <= 2'd0;
          end else begin
            bracket_run <= is_br ? br_inc : 2'd0;
            prev_sep    <= sep;
          end
        end
      end

      if (cmd.run && mode == MODE_UNDEC) begin
        if (hdr_done) begin
          mode <= MODE_ENC;
          hm   <= 4'd0;
        end else if (hdr_hold) begin
          hm <= hm + 4'd1;
        end else begin
          mode      <= MODE_PLAIN;
          flush_idx <= '0;
        end
      end
      if (cmd.run && in_dec) begin
        key_pos <= kp_next;
      end
      if (cmd.flush) begin
        flush_idx <= flush_idx + 1'b1;
      end
      if (cmd.cur) begin
        hm <= 4'd0;
      end

      if (emit) begin
        o_valid <= 1'b1;
      end else if (o_ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run && mode == MODE_UNDEC && hdr_hold) begin
      held[hm[IDX_W-1:0]] <= in_byte;
    end
    if (cmd.run) begin
      saved_byte <= in_byte;
      saved_last <= in_last;
    end
    if (emit) begin
      o_byte <= keep ? hb_byte : 8'd0;
      o_user <= {keep & mc, keep & !sep & prev_sep, keep & sep, keep};
      o_last <= hb_last;
    end
  end

  always_comb begin
    status.slot_free  = !o_valid || o_ready;
    status.need_flush = (mode == MODE_UNDEC) && hdr_miss && (hm != 4'd0);
    status.flush_done = (flush_idx == pm1[IDX_W-1:0]);
  end

  a_mode_sticky: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_UNDEC) |=> (mode != MODE_UNDEC))
    else $error("stream mode fell back to undecided");

  a_key_only_enc: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_ENC) |-> (key_pos == 4'd0))
    else $error("key position moved outside encrypted mode");

  a_flush_has_bytes: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> (hm != 4'd0 && mode == MODE_PLAIN))
    else $error("flush without held header bytes");

endmodule

// ===== rtl/keyed_text_line_decoder_top.sv =====
// top level of the keyed text line decoder
//
// input stream: one text byte per item in s_tdata, s_tlast on the last byte
// of each line. output stream: one result per kept byte or line end,
// m_tlast on the last result of a line, m_tuser carries the byte flags.
// the first line is compared case-insensitively with the header; matching
// bytes are held back. a full match drops them and switches to decryption,
// a mismatch releases them as plain text.
// configuration: cfg_index 0 writes the low separator mask, 1 the high one,
// other indexes are ignored; cfg_ready is always high.
// results are registered in the output register. throughput: one item per
// cycle while the output register has room; an item gives zero or one
// result, except the item that breaks a partial header: the held bytes
// leave the held-byte registers first, one per cycle as room allows, then
// its own result, while s_tready stays low.
// reset (rst, synchronous): masks return to defaults, header search restarts,
// the output register empties.
// a stalled receiver (m_tready low) holds the result and s_tready drops until
// the output register can take the next result.
module keyed_text_line_decoder_top import kltd_pkg::*; #(
  parameter int HEADER_LENGTH = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // data_byte
  input  logic                   s_tlast,   // last_in_line
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // out_byte
  output logic [3:0]             m_tuser,   // byte_present, is_separator, token_start, merge_conflict
  output logic                   m_tlast,   // line_end
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  kltd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  kltd_dp #(
    .HEADER_LENGTH (HEADER_LENGTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .cmd       (cmd),
    .status    (status),
    .o_valid   (m_tvalid),
    .o_ready   (m_tready),
    .o_byte    (m_tdata),
    .o_user    (m_tuser),
    .o_last    (m_tlast)
  );

endmodule

// ===== sim/keyed_text_line_decoder_top_tb.sv =====
// self-checking testbench for the keyed text line decoder: header detection, decryption, line flags
`timescale 1ns / 100ps

module keyed_text_line_decoder_top_tb import kltd_pkg::*; ();

  localparam int HDR_LEN = 9;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int DRAIN_CYCLES = HDR_LEN + 4;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'd2;
  localparam logic [HDR_TEXT_LEN*8-1:0] HDR_TEXT = "redshirt2";
  // key offsets, entry 0 in the lowest byte
  localparam logic [127:0] KEY_OFS_TABLE = {
    8'd2, 8'd27, 8'd22, 8'd35, 8'd12, 8'd40, 8'd17, 8'd3,
    8'd5, 8'd5, 8'd2, 8'd11, 8'd1, 8'd9, 8'd7, 8'd31
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       present;
    logic       separator;
    logic       tok_start;
    logic       line_end;
    logic       conflict;
  } line_result_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_style_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  logic [7:0]             m_tdata;
  logic [3:0]             m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [63:0]            cfg_data;

  // decoder state mirrored by the predictor
  logic [63:0] sep_mask_lo;
  logic [63:0] sep_mask_hi;
  mode_t       stream_mode;
  int          hdr_pos;
  logic [7:0]  held_hdr [0:15];
  logic [3:0]  key_pos;
  logic        in_comment;
  logic [1:0]  bracket_run;
  logic        prev_sep;

  line_result_t decoded_results [$];
  line_result_t want;
  line_result_t got;
  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  rx_style_t rx_style = RX_OPEN;
  int rx_left = 0;
  logic [7:0] rx_pat = 8'hA5;

  keyed_text_line_decoder_top #(.HEADER_LENGTH(HDR_LEN)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] key_ofs(input logic [3:0] k);
    return KEY_OFS_TABLE[k*8 +: 8];
  endfunction

  function automatic logic [7:0] hdr_char_at(input int p);
    return HDR_TEXT[(HDR_TEXT_LEN-1-p)*8 +: 8];
  endfunction

  function automatic logic [7:0] lower_case(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? (b ^ 8'h20) : b;
  endfunction

  function automatic logic in_sep_set(input logic [7:0] b);
    if (b < 8'd64) return sep_mask_lo[b[5:0]];
    if (b < 8'd128) return sep_mask_hi[b[5:0]];
    return 1'b0;
  endfunction

  function automatic void push_result(input logic [7:0] b, input logic present,
                                      input logic sep, input logic ts,
                                      input logic le, input logic mc);
    decoded_results.push_back('{b, present, sep, ts, le, mc});
  endfunction

  function automatic void close_line(input logic kept);
    // a line whose last byte was dropped still needs its end marker
    if (!kept) push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    in_comment = 1'b0;
    bracket_run = 2'd0;
    prev_sep = 1'b1;
  endfunction

  function automatic void keep_or_drop(input logic [7:0] b, input logic last);
    logic kept;
    logic sep;
    logic ts;
    logic mc;
    kept = 1'b0;
    if (!in_comment) begin
      if (b == BYTE_HASH) begin
        in_comment = 1'b1;
        bracket_run = 2'd0;
      end else begin
        mc = 1'b0;
        if (b == BYTE_LT || b == BYTE_GT) begin
          if (bracket_run < 2'd3) bracket_run = bracket_run + 2'd1;
          mc = (bracket_run == 2'd3);
        end else begin
          bracket_run = 2'd0;
        end
        sep = in_sep_set(b);
        ts = !sep && prev_sep;
        prev_sep = sep;
        push_result(b, 1'b1, sep, ts, last, mc);
        kept = 1'b1;
      end
    end
    if (last) close_line(kept);
  endfunction

  function automatic void predict_item(input logic [7:0] b, input logic last);
    logic hit;
    logic [7:0] d;
    int j;
    d = b;
    if (stream_mode == MODE_UNDEC) begin
      hit = (hdr_pos < HDR_TEXT_LEN) && (hdr_pos < HDR_LEN) &&
            (lower_case(b) == hdr_char_at(hdr_pos));
      if (hit && hdr_pos + 1 >= HDR_LEN) begin
        stream_mode = MODE_ENC;
        hdr_pos = 0;
        if (last) close_line(1'b0);
        return;
      end
      if (hit && !last) begin
        held_hdr[hdr_pos] = b;
        hdr_pos = hdr_pos + 1;
        return;
      end
      // header broken: held bytes go out as plain text ahead of this one
      stream_mode = MODE_PLAIN;
      for (int i = 0; i < hdr_pos; i++) keep_or_drop(held_hdr[i], 1'b0);
      hdr_pos = 0;
      keep_or_drop(b, last);
      return;
    end
    if (stream_mode == MODE_ENC && b >= DEC_LO && b <= DEC_HI) begin
      key_pos = key_pos + 4'd1;
      j = int'(b) - int'(key_ofs(key_pos));
      if (j < int'(DEC_LO)) j = j + int'(WRAP_ADD);
      d = j[7:0];
    end
    keep_or_drop(d, last);
  endfunction

  // ciphertext that decodes to p under the next key position
  function automatic logic [7:0] cipher_for(input logic [7:0] p);
    int c;
    c = int'(p) + int'(key_ofs(key_pos + 4'd1));
    if (c > int'(DEC_HI)) c = c - int'(WRAP_ADD);
    return c[7:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 64) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(b, last);
    @(negedge clk);
  endtask

  task automatic send_plain(input logic [7:0] b, input logic last);
    if (stream_mode == MODE_ENC && b >= DEC_LO && b <= DEC_HI) send_item(cipher_for(b), last);
    else send_item(b, last);
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_plain(s[i], i == s.len() - 1);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SEP_LOW) sep_mask_lo = value;
    else if (idx == REG_SEP_HIGH) sep_mask_hi = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (decoded_results.size() != 0) @(negedge clk);
    // a header flush may still be running after the last result
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_lines(input int n_items);
    string sep_chars;
    logic [7:0] text [$];
    int sent;
    int len;
    int k;
    logic [7:0] b;
    sep_chars = " \t\n\r:,";
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        text.delete();
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        while (text.size() < len) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: b = 8'($urandom_range("a", "z"));
            6, 7:             b = 8'($urandom_range("A", "Z"));
            8:                b = 8'($urandom_range("0", "9"));
            9, 10, 11:        b = sep_chars[$urandom_range(0, 5)];
            12:               b = BYTE_HASH;
            13, 14:           b = 8'($urandom_range(33, 126));
            15:               b = 8'($urandom_range(128, 255));
            16:               b = ($urandom_range(0, 1) == 0) ? DEC_HI : 8'($urandom_range(1, 31));
            default:          b = ($urandom_range(0, 1) == 0) ? BYTE_LT : BYTE_GT;
          endcase
          text.push_back(b);
          // conflict marker runs
          if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(3, 7);
            repeat (k) text.push_back(($urandom_range(0, 3) == 0) ? BYTE_GT : BYTE_LT);
          end
        end
        foreach (text[i]) send_plain(text[i], i == text.size() - 1);
        sent = sent + text.size();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(8'($urandom_range(1, 255)), $urandom_range(0, 7) == 0);
          sent++;
        end
      end
    end
  endtask

  // one run decides the stream mode once: full header, partial header or short first line
  task automatic test_header();
    int n_match;
    logic enc;
    logic [7:0] c;
    enc = ($urandom_range(0, 2) != 0);
    n_match = enc ? HDR_LEN - 1 : $urandom_range(0, HDR_LEN - 1);
    for (int i = 0; i <= n_match; i++) begin
      c = hdr_char_at(i);
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c ^ 8'h20;
      if (i < n_match) begin
        send_item(c, 1'b0);
      end else if (enc) begin
        send_item(c, 1'($urandom_range(0, 1)));
      end else if (n_match < HDR_LEN - 1 && $urandom_range(0, 1) == 1) begin
        send_item(c, 1'b1);
      end else begin
        do c = 8'($urandom_range(1, 255)); while (lower_case(c) == hdr_char_at(n_match));
        send_item(c, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_directed();
    send_line(" ab:c,<<<>x");
    send_line("<<");
    send_line("<#z");
    send_item(8'd1, 1'b0);
    send_item(8'd32, 1'b0);
    send_item(DEC_LO, 1'b0);
    send_item(DEC_HI, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hFF, 1'b1);
    send_line("#");
  endtask

  task automatic test_separator_masks();
    wait_idle();
    write_reg(REG_SEP_LOW, '1);
    write_reg(REG_SEP_HIGH, '1);
    random_lines(70);
    wait_idle();
    write_reg(REG_SEP_LOW, '0);
    write_reg(REG_SEP_HIGH, '0);
    random_lines(70);
    wait_idle();
    write_reg(REG_SEP_LOW, {$urandom, $urandom});
    write_reg(REG_SEP_HIGH, {$urandom, $urandom});
    random_lines(80);
    wait_idle();
    write_reg(REG_UNMAPPED, {$urandom, $urandom});
    write_reg('1, {$urandom, $urandom});
    random_lines(30);
  endtask

  task automatic test_random_text();
    wait_idle();
    write_reg(REG_SEP_LOW, SEP_LOW_RESET);
    write_reg(REG_SEP_HIGH, SEP_HIGH_RESET);
    random_lines(160);
  endtask

  // receiver readiness switches between random styles: open, light, heavy and a rotating pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 40);
      rx_pat = 8'($urandom);
    end else begin
      rx_left--;
    end
    rx_pat = {rx_pat[0], rx_pat[7:1]};
    case (rx_style)
      RX_OPEN:  m_tready <= 1'b1;
      RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: m_tready <= ($urandom_range(0, 2) == 0);
      default:  m_tready <= rx_pat[0];
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata, m_tuser[0], m_tuser[1], m_tuser[2], m_tlast, m_tuser[3]};
      if (decoded_results.size() == 0) begin
        report_mismatch($sformatf("result %02h with nothing expected", m_tdata));
      end else begin
        want = decoded_results.pop_front();
        if (got.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h want %02h", got.out_byte, want.out_byte));
        if (got.present !== want.present)
          report_mismatch($sformatf("byte_present %b want %b", got.present, want.present));
        if (got.separator !== want.separator)
          report_mismatch($sformatf("is_separator %b want %b (byte %02h)",
                                    got.separator, want.separator, want.out_byte));
        if (got.tok_start !== want.tok_start)
          report_mismatch($sformatf("token_start %b want %b (byte %02h)",
                                    got.tok_start, want.tok_start, want.out_byte));
        if (got.line_end !== want.line_end)
          report_mismatch($sformatf("line_end %b want %b", got.line_end, want.line_end));
        if (got.conflict !== want.conflict)
          report_mismatch($sformatf("merge_conflict %b want %b", got.conflict, want.conflict));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** keyed_text_line_decoder_top: FAILED **");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_SEP_LOW;
    cfg_data = 64'h0;
    sep_mask_lo = SEP_LOW_RESET;
    sep_mask_hi = SEP_HIGH_RESET;
    stream_mode = MODE_UNDEC;
    hdr_pos = 0;
    key_pos = 4'd0;
    in_comment = 1'b0;
    bracket_run = 2'd0;
    prev_sep = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_header();
    test_directed();
    test_separator_masks();
    test_random_text();
    wait_idle();
    if (errors == 0) begin
      $display("** keyed_text_line_decoder_top: PASSED **");
    end else begin
      $display("** keyed_text_line_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
